>>> hdl/rls_pkg.sv
// Shared types, constants and fixed-point helpers for the RLS estimator.
package rls_pkg;

    localparam int DATA_W    = 32;
    localparam int COV_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int COV_FRAC  = COV_W / 2;
    localparam int WORD_W    = 64;
    localparam int ACC_W     = 128;
    localparam int DIGIT_W   = 16;
    localparam int MUL_STEPS = WORD_W / DIGIT_W;
    localparam int CNT_W     = $clog2(ACC_W);
    localparam int NUM_REG   = 4;
    localparam int COL_W     = 3;
    localparam int LAMBDA_W  = 16;
    localparam int SIZE_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int LDIV_SHIFT = COV_FRAC - LAMBDA_W;
    localparam int DBASE_SHIFT = COV_FRAC - LAMBDA_W + FRAC_BITS;

    localparam logic [LAMBDA_W-1:0] LAMBDA_FLOOR = 16'd58982;
    localparam logic [LAMBDA_W-1:0] LAMBDA_SUBST = 16'd62259;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd64881;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 3'd4;
    localparam logic [COV_W-1:0]    COV_INIT     = COV_W'(1000) << COV_FRAC;

    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd1;

    typedef enum logic [2:0] {
        LOP_RESET, LOP_ERR, LOP_PPHI, LOP_D, LOP_GAIN, LOP_ROWV, LOP_THETA, LOP_NEWP
    } t_lop;

    typedef enum logic [2:0] {
        L_IDLE, L_LOAD, L_MUL, L_POST, L_DIV, L_FIN
    } t_lstate;

    typedef enum logic [1:0] {
        M_IDLE, M_ADD, M_FIN
    } t_mstate;

    typedef enum logic [3:0] {
        S_IDLE, S_RST, S_ERR, S_ERRM, S_PPHI, S_D, S_DM, S_GAIN,
        S_ROWV, S_ROWVM, S_THETA, S_NEWP, S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        t_lop             op;
        logic [COL_W-1:0] col;
        logic             first;
        logic             last;
    } t_lane_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] b;
        logic [DATA_W-1:0] err;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] ldiv;
    } t_lane_bus;

    typedef struct packed {
        logic done;
        logic clip;
    } t_lane_stat;

    typedef struct packed {
        logic             start;
        logic             sub;
        logic             narrow;
        logic [ACC_W-1:0] base;
        logic [COL_W:0]   n;
    } t_merge_cmd;

    typedef struct packed {
        logic              done;
        logic              clip;
        logic [WORD_W-1:0] res;
    } t_merge_res;

    typedef struct packed {
        logic [WORD_W-1:0] val;
        logic              clip;
    } t_sat;

    // Round to nearest, ties upward, then arithmetic shift
    function automatic logic [ACC_W-1:0] rnd(input logic [ACC_W-1:0] v, input int unsigned s);
        logic signed [ACC_W-1:0] t;
        t = signed'(v + (ACC_W'(1) << (s - 1)));
        return ACC_W'(t >>> s);
    endfunction

    // Clip a signed wide value into a signed field of the given width
    function automatic t_sat sat_to(input logic [ACC_W-1:0] v, input int unsigned bits);
        logic signed [ACC_W-1:0] sv;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        t_sat r;
        sv = signed'(v);
        hi = signed'((ACC_W'(1) << (bits - 1)) - ACC_W'(1));
        lo = ~hi;
        r.val  = sv[WORD_W-1:0];
        r.clip = 1'b0;
        if (sv > hi) begin
            r.val  = hi[WORD_W-1:0];
            r.clip = 1'b1;
        end else if (sv < lo) begin
            r.val  = lo[WORD_W-1:0];
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    function automatic logic [ACC_W-1:0] mag128(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    endfunction

endpackage

>>> hdl/rls_lane.sv
// One estimator lane: owns a parameter, a covariance row and a serial multiply/divide unit.
module rls_lane import rls_pkg::*; #(
    parameter int MAX_PARAMS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_cmd         i_cmd,
    input  t_lane_bus         i_bus,
    input  logic [COL_W-1:0]  i_lane_id,
    input  logic [DATA_W-1:0] i_phi,
    output t_lane_stat        o_stat,
    output logic [ACC_W-1:0]  o_prod,
    output logic [DATA_W-1:0] o_theta
);
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    t_lstate           r_st, n_st;
    t_lop              r_op;
    logic [IW-1:0]     r_col;
    logic              r_last;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_amag, r_bmag;
    logic              r_neg;
    logic [ACC_W-1:0]  r_macc, r_prod, r_acc;
    logic [WORD_W-1:0] r_pphi, r_gain;
    logic [DATA_W-1:0] r_theta;
    logic [COV_W-1:0]  r_cov [MAX_PARAMS];
    logic [ACC_W-1:0]  r_num, r_quo;
    logic [WORD_W-1:0] r_rem, r_dmag;
    logic              r_qneg;
    logic              r_done, r_clip;

    logic [COV_W-1:0]  cov_sel;
    logic [WORD_W-1:0] a_sel, b_sel;
    logic [ACC_W-1:0]  prod_s, pphi_sum, theta_sum, newp_num, quo_s, div_num;
    logic [WORD_W-1:0] div_den;
    logic [WORD_W:0]   dv_t;
    logic              dv_ge;
    logic [WORD_W+DIGIT_W-1:0] mul_p;
    t_sat              pphi_sat, theta_sat, gain_sat, cov_sat;

    assign cov_sel = r_cov[r_col];

    // Pick multiply operands for the latched operation
    always_comb begin
        a_sel = '0;
        b_sel = '0;
        case (r_op)
            LOP_ERR: begin
                a_sel = WORD_W'(signed'(i_phi));
                b_sel = WORD_W'(signed'(r_theta));
            end
            LOP_PPHI: begin
                a_sel = WORD_W'(signed'(cov_sel));
                b_sel = i_bus.b;
            end
            LOP_D: begin
                a_sel = WORD_W'(signed'(i_phi));
                b_sel = r_pphi;
            end
            LOP_ROWV: begin
                a_sel = WORD_W'(signed'(i_phi));
                b_sel = WORD_W'(signed'(cov_sel));
            end
            LOP_THETA: begin
                a_sel = r_gain;
                b_sel = WORD_W'(signed'(i_bus.err));
            end
            LOP_NEWP: begin
                a_sel = r_gain;
                b_sel = i_bus.b;
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    // Finish arithmetic
    always_comb begin
        mul_p     = {{DIGIT_W{1'b0}}, r_amag} * {{WORD_W{1'b0}}, r_bmag[WORD_W-1 -: DIGIT_W]};
        prod_s    = r_neg ? (~r_macc + ACC_W'(1)) : r_macc;
        pphi_sum  = r_acc + prod_s;
        pphi_sat  = sat_to(rnd(pphi_sum, FRAC_BITS), WORD_W);
        theta_sum = (ACC_W'(signed'(r_theta)) << COV_FRAC) + prod_s;
        theta_sat = sat_to(rnd(theta_sum, COV_FRAC), DATA_W);
        newp_num  = (ACC_W'(signed'(cov_sel)) << COV_FRAC) - prod_s;
        quo_s     = r_qneg ? (~r_quo + ACC_W'(1)) : r_quo;
        gain_sat  = sat_to(quo_s, WORD_W);
        cov_sat   = sat_to(quo_s, COV_W);
        div_num   = (r_st == L_LOAD) ? (ACC_W'(signed'(r_pphi)) << COV_FRAC) : newp_num;
        div_den   = (r_st == L_LOAD) ? i_bus.d : i_bus.ldiv;
        dv_t      = {r_rem, r_num[ACC_W-1]};
        dv_ge     = dv_t >= {1'b0, r_dmag};
    end

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            L_IDLE: if (i_cmd.start && i_cmd.op != LOP_RESET) n_st = L_LOAD;
            L_LOAD: n_st = (r_op == LOP_GAIN) ? L_DIV : L_MUL;
            L_MUL:  if (r_cnt == CNT_W'(MUL_STEPS - 1)) n_st = L_POST;
            L_POST: n_st = (r_op == LOP_NEWP) ? L_DIV : L_IDLE;
            L_DIV:  if (r_cnt == CNT_W'(ACC_W - 1)) n_st = L_FIN;
            L_FIN:  n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Datapath and lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_clip  <= 1'b0;
            r_theta <= '0;
            for (int k = 0; k < MAX_PARAMS; k++) begin
                r_cov[k] <= (COL_W'(k) == i_lane_id) ? COV_INIT : '0;
            end
        end else begin
            r_done <= 1'b0;
            r_clip <= 1'b0;
            case (r_st)
                L_IDLE: begin
                    if (i_cmd.start) begin
                        r_op   <= i_cmd.op;
                        r_col  <= i_cmd.col[IW-1:0];
                        r_last <= i_cmd.last;
                        if (i_cmd.first) r_acc <= '0;
                        if (i_cmd.op == LOP_RESET) begin
                            for (int k = 0; k < MAX_PARAMS; k++) begin
                                r_cov[k] <= (COL_W'(k) == i_lane_id) ? COV_INIT : '0;
                            end
                        end
                    end
                end
                L_LOAD: begin
                    r_cnt  <= '0;
                    r_amag <= mag64(a_sel);
                    r_bmag <= mag64(b_sel);
                    r_neg  <= a_sel[WORD_W-1] ^ b_sel[WORD_W-1];
                    r_macc <= '0;
                    r_num  <= mag128(div_num);
                    r_dmag <= mag64(div_den);
                    r_qneg <= div_num[ACC_W-1] ^ div_den[WORD_W-1];
                    r_rem  <= '0;
                    r_quo  <= '0;
                end
                L_MUL: begin
                    // One 16-bit digit of the multiplier per cycle, MSB first
                    r_macc <= (r_macc << DIGIT_W) + ACC_W'(mul_p);
                    r_bmag <= r_bmag << DIGIT_W;
                    r_cnt  <= r_cnt + CNT_W'(1);
                end
                L_POST: begin
                    r_prod <= prod_s;
                    r_cnt  <= '0;
                    case (r_op)
                        LOP_PPHI: begin
                            r_acc <= pphi_sum;
                            if (r_last) begin
                                r_pphi <= pphi_sat.val;
                                r_clip <= pphi_sat.clip;
                            end
                        end
                        LOP_THETA: begin
                            r_theta <= theta_sat.val[DATA_W-1:0];
                            r_clip  <= theta_sat.clip;
                        end
                        LOP_NEWP: begin
                            r_num  <= mag128(div_num);
                            r_dmag <= mag64(div_den);
                            r_qneg <= div_num[ACC_W-1] ^ div_den[WORD_W-1];
                            r_rem  <= '0;
                            r_quo  <= '0;
                        end
                        default: begin
                        end
                    endcase
                    r_done <= (r_op != LOP_NEWP);
                end
                L_DIV: begin
                    // Restoring division, one quotient bit per cycle
                    r_num <= r_num << 1;
                    r_rem <= dv_ge ? WORD_W'(dv_t - {1'b0, r_dmag}) : dv_t[WORD_W-1:0];
                    r_quo <= {r_quo[ACC_W-2:0], dv_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                L_FIN: begin
                    if (r_op == LOP_GAIN) begin
                        r_gain <= gain_sat.val;
                        r_clip <= gain_sat.clip;
                    end else begin
                        r_cov[r_col] <= cov_sat.val[COV_W-1:0];
                        r_clip       <= cov_sat.clip;
                    end
                    r_done <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.clip = r_clip;
    assign o_prod      = r_prod;
    assign o_theta     = r_theta;

endmodule

>>> hdl/rls_merge.sv
// Merge stage: adds or subtracts lane products onto a base value one lane per cycle, then rounds and clips.
module rls_merge import rls_pkg::*; #(
    parameter int MAX_PARAMS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_merge_cmd       i_cmd,
    input  logic [ACC_W-1:0] i_prod [MAX_PARAMS],
    output t_merge_res       o_res
);
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    t_mstate          r_st, n_st;
    logic [COL_W:0]   r_k, r_n;
    logic             r_sub, r_narrow;
    logic [ACC_W-1:0] r_acc;
    t_merge_res       r_res;
    logic [ACC_W-1:0] add_v;
    t_sat             fin_n, fin_w;
    logic             k_last;

    always_comb begin
        add_v  = r_sub ? (r_acc - i_prod[r_k[IW-1:0]]) : (r_acc + i_prod[r_k[IW-1:0]]);
        fin_n  = sat_to(rnd(r_acc, FRAC_BITS), DATA_W);
        fin_w  = sat_to(rnd(r_acc, FRAC_BITS), WORD_W);
        k_last = (r_k + (COL_W + 1)'(1)) == r_n;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            M_IDLE:  if (i_cmd.start) n_st = M_ADD;
            M_ADD:   if (k_last) n_st = M_FIN;
            M_FIN:   n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Accumulate and finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.done <= 1'b0;
        end else begin
            r_res.done <= 1'b0;
            case (r_st)
                M_IDLE: begin
                    if (i_cmd.start) begin
                        r_acc    <= i_cmd.base;
                        r_k      <= '0;
                        r_n      <= i_cmd.n;
                        r_sub    <= i_cmd.sub;
                        r_narrow <= i_cmd.narrow;
                    end
                end
                M_ADD: begin
                    r_acc <= add_v;
                    r_k   <= r_k + (COL_W + 1)'(1);
                end
                M_FIN: begin
                    r_res.done <= 1'b1;
                    r_res.clip <= r_narrow ? fin_n.clip : fin_w.clip;
                    r_res.res  <= r_narrow ? fin_n.val : fin_w.val;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/rls_parameter_estimator.sv
// Top level: sequencer, registers and output stage of the RLS parameter estimator.
// An update with N active parameters spends most of its time in the 128-step divider (gain,
// then one per covariance column). A zero denominator ends an update before the gain step.
// One request is in work at a time; the next is taken while a finished result waits in the
// output register.
// Reset (synchronous, active low): estimates 0, covariance 1000*I, lambda 0.99, size 4.
module rls_parameter_estimator import rls_pkg::*; #(
    parameter int MAX_PARAMS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic [DATA_W-1:0]    i_measured,
    input  logic [DATA_W-1:0]    i_regressor_a,
    input  logic [DATA_W-1:0]    i_regressor_b,
    input  logic [DATA_W-1:0]    i_regressor_c,
    input  logic [DATA_W-1:0]    i_regressor_d,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DATA_W-1:0]    o_prediction_error,
    output logic [DATA_W-1:0]    o_estimate_a,
    output logic [DATA_W-1:0]    o_estimate_b,
    output logic [DATA_W-1:0]    o_estimate_c,
    output logic [DATA_W-1:0]    o_estimate_d,
    output logic                 o_update_skipped,
    output logic                 o_saturated,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LAMBDA_W-1:0]  i_cfg_data
);
    localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CW = $clog2(MAX_PARAMS + 1);

    t_state             r_st, n_st;
    logic               r_go, n_go;
    logic [IW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_n;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [SIZE_W-1:0]  r_size;
    logic [DATA_W-1:0]  r_y;
    logic [DATA_W-1:0]  r_phi [MAX_PARAMS];
    logic [WORD_W-1:0]  r_rowv [MAX_PARAMS];
    logic [DATA_W-1:0]  r_err;
    logic [WORD_W-1:0]  r_d;
    logic               r_skip, r_sat;
    logic               r_oval;
    logic [DATA_W-1:0]  r_oerr;
    logic [DATA_W-1:0]  r_oest [NUM_REG];
    logic               r_oskip, r_osat;

    logic               accept, out_load, j_last;
    logic [CW-1:0]      size_eff;
    logic [DATA_W-1:0]  in_regs [NUM_REG];
    logic [DATA_W-1:0]  cap_phi [MAX_PARAMS];
    logic [DATA_W-1:0]  est [NUM_REG];
    t_lane_cmd          cmd_c;
    t_lane_cmd          lane_cmd [MAX_PARAMS];
    t_lane_bus          bus;
    t_lane_stat         lane_stat [MAX_PARAMS];
    logic [ACC_W-1:0]   lane_prod [MAX_PARAMS];
    logic [DATA_W-1:0]  lane_theta [MAX_PARAMS];
    logic               lane_clip;
    t_merge_cmd         mcmd;
    t_merge_res         mres;

    assign accept      = i_valid && !o_stall;
    assign o_stall     = !i_rst_n || (r_st != S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign out_load    = (r_st == S_OUT) && (!r_oval || !i_stall);
    assign j_last      = (CW'(r_j) + CW'(1)) == r_n;

    assign in_regs[0] = i_regressor_a;
    assign in_regs[1] = i_regressor_b;
    assign in_regs[2] = i_regressor_c;
    assign in_regs[3] = i_regressor_d;

    // Clamp the active size to 1..MAX_PARAMS
    always_comb begin
        if (r_size == '0) begin
            size_eff = CW'(1);
        end else if (int'(r_size) > MAX_PARAMS) begin
            size_eff = CW'(MAX_PARAMS);
        end else begin
            size_eff = CW'(r_size);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= LAMBDA_RESET;
            r_size   <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LAMBDA: r_lambda <= (i_cfg_data <= LAMBDA_FLOOR) ? LAMBDA_SUBST : i_cfg_data;
                REG_SIZE:   r_size   <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Lanes and merge stage
    genvar g;
    generate
        for (g = 0; g < MAX_PARAMS; g++) begin : g_lane
            if (g < NUM_REG) begin : g_in
                assign cap_phi[g] = in_regs[g];
            end else begin : g_zero
                assign cap_phi[g] = '0;
            end
            rls_lane #(.MAX_PARAMS(MAX_PARAMS)) u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (lane_cmd[g]),
                .i_bus     (bus),
                .i_lane_id (COL_W'(g)),
                .i_phi     (r_phi[g]),
                .o_stat    (lane_stat[g]),
                .o_prod    (lane_prod[g]),
                .o_theta   (lane_theta[g])
            );
        end
        for (g = 0; g < NUM_REG; g++) begin : g_est
            if (g < MAX_PARAMS) begin : g_have
                assign est[g] = lane_theta[g];
            end else begin : g_none
                assign est[g] = '0;
            end
        end
    endgenerate

    rls_merge #(.MAX_PARAMS(MAX_PARAMS)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mcmd),
        .i_prod  (lane_prod),
        .o_res   (mres)
    );

    // Lane commands and broadcast operands
    always_comb begin
        cmd_c.start = r_go;
        cmd_c.op    = LOP_ERR;
        cmd_c.col   = COL_W'(r_j);
        cmd_c.first = (r_j == '0);
        cmd_c.last  = j_last;
        case (r_st)
            S_RST:   cmd_c.op = LOP_RESET;
            S_ERR:   cmd_c.op = LOP_ERR;
            S_PPHI:  cmd_c.op = LOP_PPHI;
            S_D:     cmd_c.op = LOP_D;
            S_GAIN:  cmd_c.op = LOP_GAIN;
            S_ROWV:  cmd_c.op = LOP_ROWV;
            S_THETA: cmd_c.op = LOP_THETA;
            S_NEWP:  cmd_c.op = LOP_NEWP;
            default: cmd_c.start = 1'b0;
        endcase
        for (int k = 0; k < MAX_PARAMS; k++) begin
            lane_cmd[k]       = cmd_c;
            lane_cmd[k].start = cmd_c.start && ((cmd_c.op == LOP_RESET) || (k < int'(r_n)));
        end

        bus.b    = (r_st == S_PPHI) ? WORD_W'(signed'(r_phi[r_j])) : r_rowv[r_j];
        bus.err  = r_err;
        bus.d    = r_d;
        bus.ldiv = WORD_W'(r_lambda) << LDIV_SHIFT;

        mcmd.start  = r_go && (r_st == S_ERRM || r_st == S_DM || r_st == S_ROWVM);
        mcmd.sub    = (r_st == S_ERRM);
        mcmd.narrow = (r_st == S_ERRM);
        mcmd.n      = (COL_W + 1)'(r_n);
        case (r_st)
            S_ERRM:  mcmd.base = ACC_W'(signed'(r_y)) << FRAC_BITS;
            S_DM:    mcmd.base = ACC_W'(r_lambda) << DBASE_SHIFT;
            default: mcmd.base = '0;
        endcase

        lane_clip = 1'b0;
        for (int k = 0; k < MAX_PARAMS; k++) begin
            lane_clip = lane_clip | (lane_stat[k].done & lane_stat[k].clip);
        end
    end

    // Sequencer: next state
    always_comb begin
        n_st = r_st;
        n_go = 1'b0;
        n_j  = r_j;
        unique case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_st = i_mode ? S_RST : S_ERR;
                    n_go = 1'b1;
                end
            end
            S_RST: n_st = S_OUT;
            S_ERR: begin
                if (lane_stat[0].done) begin
                    n_st = S_ERRM;
                    n_go = 1'b1;
                end
            end
            S_ERRM: begin
                if (mres.done) begin
                    n_st = S_PPHI;
                    n_go = 1'b1;
                    n_j  = '0;
                end
            end
            S_PPHI: begin
                if (lane_stat[0].done) begin
                    n_go = 1'b1;
                    if (j_last) begin
                        n_st = S_D;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
            end
            S_D: begin
                if (lane_stat[0].done) begin
                    n_st = S_DM;
                    n_go = 1'b1;
                end
            end
            S_DM: begin
                if (mres.done) begin
                    if (mres.res == '0) begin
                        n_st = S_OUT;
                    end else begin
                        n_st = S_GAIN;
                        n_go = 1'b1;
                    end
                end
            end
            S_GAIN: begin
                if (lane_stat[0].done) begin
                    n_st = S_ROWV;
                    n_go = 1'b1;
                    n_j  = '0;
                end
            end
            S_ROWV: begin
                if (lane_stat[0].done) begin
                    n_st = S_ROWVM;
                    n_go = 1'b1;
                end
            end
            S_ROWVM: begin
                if (mres.done) begin
                    n_go = 1'b1;
                    if (j_last) begin
                        n_st = S_THETA;
                    end else begin
                        n_st = S_ROWV;
                        n_j  = r_j + IW'(1);
                    end
                end
            end
            S_THETA: begin
                if (lane_stat[0].done) begin
                    n_st = S_NEWP;
                    n_go = 1'b1;
                    n_j  = '0;
                end
            end
            S_NEWP: begin
                if (lane_stat[0].done) begin
                    if (j_last) begin
                        n_st = S_OUT;
                    end else begin
                        n_go = 1'b1;
                        n_j  = r_j + IW'(1);
                    end
                end
            end
            S_OUT: if (out_load) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_go <= 1'b0;
            r_j  <= '0;
        end else begin
            r_st <= n_st;
            r_go <= n_go;
            r_j  <= n_j;
        end
    end

    // Request capture and merge results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y    <= i_measured;
            r_n    <= size_eff;
            r_err  <= '0;
            r_skip <= 1'b0;
            r_sat  <= 1'b0;
            for (int k = 0; k < MAX_PARAMS; k++) begin
                r_phi[k] <= cap_phi[k];
            end
        end else begin
            r_sat <= r_sat | lane_clip | (mres.done & mres.clip);
            if (mres.done) begin
                case (r_st)
                    S_ERRM: r_err <= mres.res[DATA_W-1:0];
                    S_DM: begin
                        r_d    <= mres.res;
                        r_skip <= (mres.res == '0);
                    end
                    S_ROWVM: r_rowv[r_j] <= mres.res;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (out_load) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oerr  <= r_err;
            r_oskip <= r_skip;
            r_osat  <= r_sat;
            for (int k = 0; k < NUM_REG; k++) begin
                r_oest[k] <= est[k];
            end
        end
    end

    assign o_valid            = r_oval;
    assign o_prediction_error = r_oerr;
    assign o_estimate_a       = r_oest[0];
    assign o_estimate_b       = r_oest[1];
    assign o_estimate_c       = r_oest[2];
    assign o_estimate_d       = r_oest[3];
    assign o_update_skipped   = r_oskip;
    assign o_saturated        = r_osat;

endmodule

>>> hdl/rls_checker.sv
// Port-level checks for the RLS estimator, bound to the top level.
module rls_checker import rls_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_prediction_error,
    input logic [DATA_W-1:0] o_estimate_a,
    input logic              o_update_skipped,
    input logic              o_saturated
);
    // A taken request keeps the input side busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input side not busy after a request");

    // A new result appears only while a request is in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a request in work");

    // Keep the handshake outputs known
    a_known_handshake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall}))
        else $error("handshake output unknown");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_prediction_error)
            && $stable(o_estimate_a) && $stable(o_update_skipped) && $stable(o_saturated)))
        else $error("stalled result changed");

endmodule

bind rls_parameter_estimator rls_checker u_rls_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_prediction_error (o_prediction_error),
    .o_estimate_a       (o_estimate_a),
    .o_update_skipped   (o_update_skipped),
    .o_saturated        (o_saturated)
);
